// ===== src/sse_pkg.sv =====
// shared types and constants for the sparse set engine
// used by sse_ctrl, sse_datapath and sparse_set_engine
package sse_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int VAL_W   = 10;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TEST   = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_INDEX = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        logic look;
        logic exec;
    } cmd_t;

endpackage

// ===== src/sparse_set_engine.sv =====
// top level of the sparse set engine: stream ports, configuration port, assertions
// depends on sse_pkg, sse_ctrl and sse_datapath
//
// Sparse set over the values 0 to active_size-1 (at most 1024), held as a dense
// member array, a position array and a member count. Each operation (add, remove,
// test, read at index, clear) passes through the look and exec states before its
// result is registered, set by the dependent memory reads: the position of the
// value first, then the dense entry at that position or index; updates are written
// in the exec state. The next operation is taken once the block is back in idle
// and the result register is free or being drained. Values at or above active_size
// are flagged and change nothing. After reset the position memory is cleared,
// during which s_tready stays low; the dense memory needs no initial contents.
module sparse_set_engine
    import sse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value [9:0], index [19:10], zero pad
    input  logic [2:0]  s_tuser,   // func [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // was_member [0], element [10:1], count [21:11], status [23:22]
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);

    cmd_t             cmd;
    logic             init_done;
    logic             was_member;
    logic [VAL_W-1:0] element;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
    logic             s_xfer;

    sse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    sse_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .func_in     (op_t'(s_tuser)),
        .value_in    (s_tdata[9:0]),
        .index_in    (s_tdata[19:10]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .init_done   (init_done),
        .was_member  (was_member),
        .element     (element),
        .count       (count),
        .status      (status)
    );

    assign m_tdata = {status, count, element, was_member};
    assign s_xfer  = s_tvalid && s_tready;

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready ##1 !s_tready)
        else $error("input taken while an operation is in flight");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> ##3 m_tvalid)
        else $error("result missing three cycles after transfer");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count <= CNT_W'(DEPTH)))
        else $error("member count above universe");

    a_element_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status != ST_OK) |-> (element == '0 && !(status == ST_INDEX && was_member)))
        else $error("element or membership set on a failed operation");

endmodule

// ===== src/sse_ctrl.sv =====
// operation sequencer and result handshake for the sparse set engine
// depends on sse_pkg; drives the datapath through cmd_t
module sse_ctrl
    import sse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic init_done,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && init_done && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    assign cmd.accept = accept;
    assign cmd.look   = (state_reg == S_LOOK);
    assign cmd.exec   = (state_reg == S_EXEC);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_LOOK;
            S_LOOK: state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (state_reg == S_EXEC) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== src/sse_datapath.sv =====
// dense and position memories, member count, size register and result registers
// depends on sse_pkg; sequenced by sse_ctrl through cmd_t
module sse_datapath
    import sse_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    input  op_t              func_in,
    input  logic [VAL_W-1:0] value_in,
    input  logic [VAL_W-1:0] index_in,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    output logic             init_done,
    output logic             was_member,
    output logic [VAL_W-1:0] element,
    output logic [CNT_W-1:0] count,
    output logic [ST_W-1:0]  status
);

    logic [ADDR_W-1:0] dense_mem [DEPTH];
    logic [ADDR_W-1:0] pos_mem   [DEPTH];

    op_t               func_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  index_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] pos_rd_reg;
    logic [ADDR_W-1:0] dense_a_rd_reg;
    logic [ADDR_W-1:0] dense_b_rd_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              was_reg;
    logic [VAL_W-1:0]  elem_reg;
    logic [CNT_W-1:0]  res_count_reg;
    status_t           status_reg;

    logic              was_c;
    logic [VAL_W-1:0]  elem_c;
    status_t           status_c;
    logic              in_range;
    logic              member;
    logic              p_we, d_we;
    logic [ADDR_W-1:0] p_waddr, p_wdata, d_waddr, d_wdata;
    logic [ADDR_W-1:0] d_raddr_a, d_raddr_b;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg  <= func_in;
            value_reg <= value_in;
            index_reg <= index_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= CNT_W'(DEPTH);
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    // position memory is zeroed once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign init_done = !clr_busy_reg;

    // position lookup of the value, then dense lookup at that position or the index
    assign d_raddr_a = (func_reg == OP_READ) ? index_reg : pos_rd_reg;
    assign d_raddr_b = count_reg[ADDR_W-1:0] - ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            pos_mem[clr_addr_reg] <= '0;
        end else if (p_we) begin
            pos_mem[p_waddr] <= p_wdata;
        end
        if (cmd.accept) begin
            pos_rd_reg <= pos_mem[value_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (d_we) begin
            dense_mem[d_waddr] <= d_wdata;
        end
        if (cmd.look) begin
            dense_a_rd_reg <= dense_mem[d_raddr_a];
        end
        if (cmd.accept) begin
            dense_b_rd_reg <= dense_mem[d_raddr_b];
        end
    end

    assign in_range = {1'b0, value_reg} < size_reg;
    assign member   = ({1'b0, pos_rd_reg} < count_reg) && (dense_a_rd_reg == value_reg);

    always_comb begin
        was_c      = 1'b0;
        elem_c     = '0;
        status_c   = ST_OK;
        count_next = count_reg;
        p_we       = 1'b0;
        d_we       = 1'b0;
        p_waddr    = value_reg;
        p_wdata    = count_reg[ADDR_W-1:0];
        d_waddr    = count_reg[ADDR_W-1:0];
        d_wdata    = value_reg;
        unique case (func_reg)
            OP_ADD, OP_REMOVE, OP_TEST: begin
                if (!in_range) begin
                    status_c = ST_RANGE;
                end else begin
                    was_c = member;
                    if (func_reg == OP_ADD && !member && count_reg < CNT_W'(DEPTH)) begin
                        p_we       = cmd.exec;
                        d_we       = cmd.exec;
                        count_next = count_reg + CNT_W'(1);
                    end else if (func_reg == OP_REMOVE && member) begin
                        // last member moves into the freed slot
                        d_waddr    = pos_rd_reg;
                        d_wdata    = dense_b_rd_reg;
                        p_waddr    = dense_b_rd_reg;
                        p_wdata    = pos_rd_reg;
                        p_we       = cmd.exec;
                        d_we       = cmd.exec;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            OP_READ: begin
                if ({1'b0, index_reg} < count_reg) begin
                    elem_c = dense_a_rd_reg;
                end else begin
                    status_c = ST_INDEX;
                end
            end
            OP_CLEAR: count_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            was_reg       <= was_c;
            elem_reg      <= elem_c;
            res_count_reg <= count_next;
            status_reg    <= status_c;
        end
    end

    assign was_member = was_reg;
    assign element    = elem_reg;
    assign count      = res_count_reg;
    assign status     = status_reg;

endmodule
